>>> rtl/srs_pkg.sv
// Sensor reading statistics: shared types and constants.
// Payload structs, command/status structs, register indexes and reset values.
// No dependencies.
package srs_pkg;

  localparam int TEMP_W = 15;
  localparam int CNT_W  = 8;
  localparam int SUM_W  = 23;
  localparam int NUM_BANDS = 4;

  localparam int STEP_W    = $clog2(SUM_W);
  localparam int DIV_STEPS = SUM_W;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_ALARM_LEVEL = 2'd0;
  localparam logic [1:0] REG_NORMAL      = 2'd1;
  localparam logic [1:0] REG_WARNING     = 2'd2;
  localparam logic [1:0] REG_CRITICAL    = 2'd3;

  localparam logic [TEMP_W-1:0] ALARM_LEVEL_RST = 15'd720;
  localparam logic [TEMP_W-1:0] NORMAL_RST      = 15'd400;
  localparam logic [TEMP_W-1:0] WARNING_RST     = 15'd640;
  localparam logic [TEMP_W-1:0] CRITICAL_RST    = 15'd960;

  typedef struct packed {
    logic signed [15:0] reading;
    logic               last_reading;
  } in_t;

  typedef struct packed {
    logic [TEMP_W-1:0] min_temp;
    logic [TEMP_W-1:0] max_temp;
    logic [TEMP_W-1:0] avg_temp;
    logic [CNT_W-1:0]  normal_count;
    logic [CNT_W-1:0]  warning_count;
    logic [CNT_W-1:0]  critical_count;
    logic [CNT_W-1:0]  shutdown_count;
    logic [CNT_W-1:0]  skipped_count;
    logic [CNT_W-1:0]  valid_count;
    logic [CNT_W-1:0]  first_alarm_index;
    logic              alarm_seen;
    logic              no_valid;
  } out_t;

  typedef struct packed {
    logic [TEMP_W-1:0] alarm_level;
    logic [TEMP_W-1:0] normal_limit;
    logic [TEMP_W-1:0] warning_limit;
    logic [TEMP_W-1:0] critical_limit;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // fold the reading into the run
    logic start;     // snapshot run, load divider, clear run
    logic step;      // one divider iteration
    logic load_out;  // move summary to the output register
  } srs_cmd_t;

  // handshake state seen by the controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic out_busy;
  } srs_sts_t;

endpackage

>>> rtl/sensor_reading_statistics_unit.sv
// Sensor reading statistics unit: run min/max/mean, band histogram, alarm index.
// Non-closing readings are taken one per cycle unless a closing reading is in
// progress. A closing reading holds the input through the snapshot, a 23-step
// serial divider and output load; the load waits if the previous summary is unread.
// Reset (synchronous, active low) clears the run, empties the output register and
// restores limits to 720/400/640/960.
module sensor_reading_statistics_unit #(
  parameter int MAX_READINGS = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  srs_pkg::in_t                in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output srs_pkg::out_t               out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srs_pkg::ADDR_W-1:0]  paddr,
  input  logic [srs_pkg::DATA_W-1:0]  pwdata,
  output logic [srs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import srs_pkg::*;

  cfg_t     cfg_r;
  srs_cmd_t cmd;
  srs_sts_t sts;
  out_t     result;
  out_t     out_r;
  logic     out_valid_r;
  logic     wr_en;
  logic [TEMP_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_level    <= ALARM_LEVEL_RST;
      cfg_r.normal_limit   <= NORMAL_RST;
      cfg_r.warning_limit  <= WARNING_RST;
      cfg_r.critical_limit <= CRITICAL_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ALARM_LEVEL: cfg_r.alarm_level    <= pwdata[TEMP_W-1:0];
        REG_NORMAL:      cfg_r.normal_limit   <= pwdata[TEMP_W-1:0];
        REG_WARNING:     cfg_r.warning_limit  <= pwdata[TEMP_W-1:0];
        REG_CRITICAL:    cfg_r.critical_limit <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ALARM_LEVEL: rd_val = cfg_r.alarm_level;
      REG_NORMAL:      rd_val = cfg_r.normal_limit;
      REG_WARNING:     rd_val = cfg_r.warning_limit;
      REG_CRITICAL:    rd_val = cfg_r.critical_limit;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

  assign sts.in_valid = in_valid;
  assign sts.in_last  = in_item.last_reading;
  assign sts.out_busy = out_valid_r && out_stall;

  srs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  srs_dp #(
    .MAX_READINGS (MAX_READINGS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .item   (in_item),
    .cfg    (cfg_r),
    .result (result)
  );

  // output register, freed when the summary is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> rtl/srs_ctrl.sv
// Sensor reading statistics: controller state machine.
// Sequences accumulate, snapshot, serial divide and output load.
// Depends on srs_pkg.
module srs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  srs_pkg::srs_sts_t sts,
  output srs_pkg::srs_cmd_t cmd,
  output logic              in_stall
);
  import srs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = sts.in_valid;
        if (sts.in_valid && sts.in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

>>> rtl/srs_dp.sv
// Sensor reading statistics: datapath.
// Run accumulators, band counters, alarm capture and restoring divider.
// Depends on srs_pkg.
module srs_dp #(
  parameter int MAX_READINGS = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srs_pkg::srs_cmd_t cmd,
  input  srs_pkg::in_t      item,
  input  srs_pkg::cfg_t     cfg,
  output srs_pkg::out_t     result
);
  import srs_pkg::*;

  localparam int COUNT_CAP = (MAX_READINGS < 255) ? MAX_READINGS : 255;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(COUNT_CAP);

  // run state
  logic [TEMP_W-1:0] min_r, max_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  valid_r, skipped_r, alarm_idx_r;
  logic              alarm_r;
  logic [CNT_W-1:0]  band_r [NUM_BANDS];

  // snapshot of a closed run and divider
  logic [TEMP_W-1:0] h_min_r, h_max_r;
  logic [CNT_W-1:0]  h_valid_r, h_skipped_r, h_alarm_idx_r;
  logic              h_alarm_r;
  logic [CNT_W-1:0]  h_band_r [NUM_BANDS];
  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  rem_r;

  logic [TEMP_W-1:0] r;
  logic              neg, take;
  logic [1:0]        band;
  logic [CNT_W:0]    rem_sh, rem_diff;
  logic              q_bit;

  assign neg  = item.reading[15];
  assign r    = item.reading[TEMP_W-1:0];
  assign take = cmd.accept && !neg && (valid_r < CAP);

  always_comb begin
    priority if (r < cfg.normal_limit) begin
      band = 2'd0;
    end else if (r < cfg.warning_limit) begin
      band = 2'd1;
    end else if (r < cfg.critical_limit) begin
      band = 2'd2;
    end else begin
      band = 2'd3;
    end
  end

  assign rem_sh   = {rem_r, dvd_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, h_valid_r};
  assign q_bit    = (rem_sh >= {1'b0, h_valid_r});

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      valid_r     <= '0;
      skipped_r   <= '0;
      alarm_idx_r <= '0;
      alarm_r     <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_r[i] <= '0;
      end
    end else begin
      if (cmd.accept && neg && (skipped_r < CAP)) begin
        skipped_r <= skipped_r + 1'b1;
      end
      if (take) begin
        if (valid_r == '0 || r < min_r) min_r <= r;
        if (valid_r == '0 || r > max_r) max_r <= r;
        sum_r   <= sum_r + SUM_W'(r);
        valid_r <= valid_r + 1'b1;
        for (int i = 0; i < NUM_BANDS; i++) begin
          if (band == 2'(i)) band_r[i] <= band_r[i] + 1'b1;
        end
        if (!alarm_r && r >= cfg.alarm_level) begin
          alarm_r     <= 1'b1;
          alarm_idx_r <= valid_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      h_min_r       <= min_r;
      h_max_r       <= max_r;
      h_valid_r     <= valid_r;
      h_skipped_r   <= skipped_r;
      h_alarm_idx_r <= alarm_idx_r;
      h_alarm_r     <= alarm_r;
      for (int i = 0; i < NUM_BANDS; i++) begin
        h_band_r[i] <= band_r[i];
      end
      dvd_r <= sum_r;
      rem_r <= '0;
    end else if (cmd.step) begin
      // restoring division, one quotient bit per cycle
      rem_r <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
    end
  end

  always_comb begin
    result.no_valid          = (h_valid_r == '0);
    result.min_temp          = result.no_valid ? '0 : h_min_r;
    result.max_temp          = result.no_valid ? '0 : h_max_r;
    result.avg_temp          = result.no_valid ? '0 : dvd_r[TEMP_W-1:0];
    result.normal_count      = h_band_r[0];
    result.warning_count     = h_band_r[1];
    result.critical_count    = h_band_r[2];
    result.shutdown_count    = h_band_r[3];
    result.skipped_count     = h_skipped_r;
    result.valid_count       = h_valid_r;
    result.first_alarm_index = h_alarm_idx_r;
    result.alarm_seen        = h_alarm_r;
  end

endmodule

>>> verif/tb.sv
// Testbench for sensor_reading_statistics_unit: run min/max/mean, band histogram and alarm index.
// Uses a built-in predictor of the run statistics and checks every summary against it.
// Depends on rtl/srs_pkg.sv and rtl/sensor_reading_statistics_unit.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  localparam int READING_CAP = 255;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_item;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  sensor_reading_statistics_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predicted configuration and run statistics
  cfg_t         limits = {ALARM_LEVEL_RST, NORMAL_RST, WARNING_RST, CRITICAL_RST};
  logic [14:0]  run_min      = '0;
  logic [14:0]  run_max      = '0;
  logic [22:0]  run_sum      = '0;
  logic [7:0]   valid_seen   = '0;
  logic [7:0]   skipped_seen = '0;
  logic [7:0]   band_cnt [4] = '{default: '0};
  logic [7:0]   alarm_idx    = '0;
  logic         alarm_hit    = 1'b0;

  out_t         expected_summaries [$];
  out_t         want;
  int           mismatches    = 0;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch at %0t: %s", $realtime, msg);
  endfunction

  function automatic logic [14:0] limit_value(logic [1:0] idx);
    logic [14:0] v;
    case (idx)
      REG_ALARM_LEVEL: v = limits.alarm_level;
      REG_NORMAL:      v = limits.normal_limit;
      REG_WARNING:     v = limits.warning_limit;
      default:         v = limits.critical_limit;
    endcase
    return v;
  endfunction

  // Folds one accepted request into the run; a closing request queues its summary.
  task automatic account_reading(in_t req);
    logic [14:0] r;
    int          band;
    out_t        s;
    if (req.reading[15]) begin
      if (skipped_seen < READING_CAP) skipped_seen++;
    end else if (valid_seen < READING_CAP) begin
      r = req.reading[14:0];
      if (valid_seen == 0 || r < run_min) run_min = r;
      if (valid_seen == 0 || r > run_max) run_max = r;
      run_sum = run_sum + r;
      valid_seen++;
      if (r < limits.normal_limit) band = 0;
      else if (r < limits.warning_limit) band = 1;
      else if (r < limits.critical_limit) band = 2;
      else band = 3;
      band_cnt[band]++;
      if (!alarm_hit && r >= limits.alarm_level) begin
        alarm_hit = 1'b1;
        alarm_idx = valid_seen;
      end
    end
    if (req.last_reading) begin
      s.no_valid          = (valid_seen == 0);
      s.min_temp          = s.no_valid ? '0 : run_min;
      s.max_temp          = s.no_valid ? '0 : run_max;
      s.avg_temp          = s.no_valid ? '0 : 15'(run_sum / valid_seen);
      s.normal_count      = band_cnt[0];
      s.warning_count     = band_cnt[1];
      s.critical_count    = band_cnt[2];
      s.shutdown_count    = band_cnt[3];
      s.skipped_count     = skipped_seen;
      s.valid_count       = valid_seen;
      s.first_alarm_index = alarm_idx;
      s.alarm_seen        = alarm_hit;
      expected_summaries.push_back(s);
      run_min      = '0;
      run_max      = '0;
      run_sum      = '0;
      valid_seen   = '0;
      skipped_seen = '0;
      band_cnt     = '{default: '0};
      alarm_idx    = '0;
      alarm_hit    = 1'b0;
    end
  endtask

  // Valid stays high between back-to-back requests; only an idle cycle lowers it.
  task automatic send_reading(logic [15:0] value, logic last);
    in_t req;
    req.reading      = value;
    req.last_reading = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    account_reading(req);
  endtask

  // Drop valid, wait for every summary, then let the last non-closing request settle.
  task automatic settle_run();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [14:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // upper bits are junk the block must drop
    pwdata  <= ($urandom() & 32'hFFFF_8000) | value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ALARM_LEVEL: limits.alarm_level    = value;
      REG_NORMAL:      limits.normal_limit   = value;
      REG_WARNING:     limits.warning_limit  = value;
      default:         limits.critical_limit = value;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_limit(logic [1:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[14:0] !== limit_value(idx))
      note_mismatch($sformatf("register %0d read: expected %0d, got %0d",
                              idx, limit_value(idx), prdata[14:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_limits(logic [14:0] alarm, logic [14:0] normal,
                              logic [14:0] warning, logic [14:0] critical);
    settle_run();
    write_limit(REG_ALARM_LEVEL, alarm);
    write_limit(REG_NORMAL, normal);
    write_limit(REG_WARNING, warning);
    write_limit(REG_CRITICAL, critical);
    read_limit(REG_ALARM_LEVEL);
    read_limit(REG_NORMAL);
    read_limit(REG_WARNING);
    read_limit(REG_CRITICAL);
  endtask

  task automatic apply_sorted_limits();
    int lims [$];
    lims = {$urandom_range(0, 1500), $urandom_range(0, 1500), $urandom_range(0, 1500)};
    lims.sort();
    apply_limits(15'($urandom_range(0, 1500)), 15'(lims[0]), 15'(lims[1]), 15'(lims[2]));
  endtask

  // Mostly ordinary temperatures, with skips and values right at the limits.
  function automatic logic [15:0] pick_reading();
    int lim;
    case ($urandom_range(9))
      0, 1: return 16'h8000 | 16'($urandom_range(0, 32767));
      2: begin
        lim = int'(limit_value(2'($urandom_range(3)))) + int'($urandom_range(2)) - 1;
        if (lim < 0) lim = 0;
        if (lim > 32767) lim = 32767;
        return 16'(lim);
      end
      3: return 16'($urandom_range(0, 32767));
      default: return 16'($urandom_range(0, 1200));
    endcase
  endfunction

  task automatic run_random_runs(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_reading(pick_reading(), i == len - 1);
      sent += len;
    end
  endtask

  task automatic test_reset_values();
    read_limit(REG_ALARM_LEVEL);
    read_limit(REG_NORMAL);
    read_limit(REG_WARNING);
    read_limit(REG_CRITICAL);
  endtask

  task automatic test_directed_runs();
    send_reading(16'd0, 1'b1);
    send_reading(16'h7FFF, 1'b1);
    // runs with nothing valid
    send_reading(16'h8000, 1'b1);
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'hFFFE, 1'b1);
    // band edges at the default limits, first alarm at 720 only
    send_reading(16'd399, 1'b0);
    send_reading(16'd400, 1'b0);
    send_reading(16'd639, 1'b0);
    send_reading(16'd640, 1'b0);
    send_reading(16'd719, 1'b0);
    send_reading(16'd720, 1'b0);
    send_reading(16'd959, 1'b0);
    send_reading(16'd960, 1'b0);
    send_reading(16'd721, 1'b1);
    // skips do not advance the alarm index
    send_reading(16'hFFFB, 1'b0);
    send_reading(16'd800, 1'b0);
    send_reading(16'h8000, 1'b0);
    send_reading(16'd10, 1'b1);
    // truncated average
    send_reading(16'd3, 1'b0);
    send_reading(16'd4, 1'b1);
  endtask

  task automatic test_band_limits();
    apply_limits('0, '0, '0, '0);
    run_random_runs(60);
    apply_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    run_random_runs(60);
    // limits out of order leave bands unreachable
    apply_limits(15'($urandom_range(0, 1200)), 15'($urandom_range(600, 1000)),
                 15'($urandom_range(0, 300)), 15'($urandom_range(300, 600)));
    run_random_runs(60);
    apply_sorted_limits();
    run_random_runs(60);
  endtask

  // Both counters pass the cap; valid readings past it must not touch min/max/sum.
  task automatic test_count_cap();
    apply_limits(15'd720, NORMAL_RST, WARNING_RST, CRITICAL_RST);
    for (int i = 0; i < 262; i++) begin
      send_reading(16'($urandom_range(100, 1000)), 1'b0);
      send_reading(16'h8000 | 16'($urandom_range(0, 32767)), 1'b0);
    end
    send_reading(16'd0, 1'b0);
    send_reading(16'h7FFF, 1'b0);
    send_reading(16'hFFFF, 1'b1);
  endtask

  task automatic test_random_runs(int count);
    apply_sorted_limits();
    run_random_runs(count);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v)
      note_mismatch($sformatf("%s: expected %0d, got %0d", name, want_v, got_v));
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_summaries.size() == 0) begin
        note_mismatch("summary with no closed run waiting");
      end else begin
        want = expected_summaries.pop_front();
        check_field("min_temp", want.min_temp, out_item.min_temp);
        check_field("max_temp", want.max_temp, out_item.max_temp);
        check_field("avg_temp", want.avg_temp, out_item.avg_temp);
        check_field("normal_count", want.normal_count, out_item.normal_count);
        check_field("warning_count", want.warning_count, out_item.warning_count);
        check_field("critical_count", want.critical_count, out_item.critical_count);
        check_field("shutdown_count", want.shutdown_count, out_item.shutdown_count);
        check_field("skipped_count", want.skipped_count, out_item.skipped_count);
        check_field("valid_count", want.valid_count, out_item.valid_count);
        check_field("first_alarm_index", want.first_alarm_index,
                    out_item.first_alarm_index);
        check_field("alarm_seen", want.alarm_seen, out_item.alarm_seen);
        check_field("no_valid", want.no_valid, out_item.no_valid);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 17;
    stall_pct     = 51;
    test_reset_values();
    test_directed_runs();
    test_band_limits();

    send_idle_pct = 51;
    stall_pct     = 17;
    test_count_cap();
    test_random_runs(180);

    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_runs(180);

    settle_run();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
